// ===== hw/rtl/contact_normal_force_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the contact normal force block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CONTACT_NORMAL_FORCE_TOP_MACROS_SVH
`define CONTACT_NORMAL_FORCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("contact normal force check failed");

// Implication with a fixed delay in cycles, disabled while reset is asserted.
`define CNF_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("contact normal force latency check failed");

`endif

// ===== hw/rtl/cnf_pkg.sv =====
// ----------------------------------------------------------------------------
// Contact normal force package
// Beat types, mode codes and pipeline constants shared by all modules.
// ----------------------------------------------------------------------------
package cnf_pkg;

    typedef struct packed {
        logic        [31:0] stiffness;
        logic        [31:0] damping;
        logic signed [31:0] overlap_depth;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_cnf_in;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               force_zeroed;
        logic               saturated;
    } t_cnf_out;

    typedef enum logic [2:0] {
        MODE_LINEAR     = 3'd0,
        MODE_HERTZ      = 3'd1,
        MODE_NO_TENSION = 3'd2,
        MODE_BONDED     = 3'd3,
        MODE_BONDED_NT  = 3'd4
    } t_cnf_mode;

    // Force, spring and damping part, square and sum widths.
    localparam int CNF_FORCE_W = 48;
    localparam int CNF_PART_W  = 50;
    localparam int CNF_SQ_W    = 2 * CNF_PART_W;
    localparam int CNF_SUM_W   = CNF_SQ_W + 2;

    // Square root of a 48-bit radicand, one result bit per stage.
    localparam int CNF_RAD_W        = 48;
    localparam int CNF_ROOT_W       = CNF_RAD_W / 2;
    localparam int CNF_SQRT_STAGES  = CNF_ROOT_W;

    // Front stages after the root, stages of the square-magnitude unit.
    localparam int CNF_MID_STAGES   = 5;
    localparam int CNF_SQ_STAGES    = 4;
    localparam int CNF_LATENCY      = 1 + CNF_SQRT_STAGES + CNF_MID_STAGES
                                      + CNF_SQ_STAGES + 1;

    localparam logic signed [CNF_FORCE_W-1:0] CNF_FMAX = {1'b0, {(CNF_FORCE_W-1){1'b1}}};
    localparam logic signed [CNF_FORCE_W-1:0] CNF_FMIN = {1'b1, {(CNF_FORCE_W-1){1'b0}}};

    // Force path values travelling beside the square-magnitude unit.
    typedef struct packed {
        logic signed [CNF_FORCE_W-1:0] f_x;
        logic signed [CNF_FORCE_W-1:0] f_y;
        logic signed [CNF_FORCE_W-1:0] f_z;
        logic                          f_sat;
        logic                          s_sat;
        logic                          zero_en;
    } t_cnf_tail;

endpackage

// ===== hw/rtl/contact_normal_force_top.sv =====
// ----------------------------------------------------------------------------
// Contact normal force, top level
// Spring-dashpot normal force of one contact per beat, five force modes.
// ----------------------------------------------------------------------------
// Usage. A contact beat enters on i_item when start is high and busy is low.
// busy never rises: the pipeline has no hazards and takes a beat every
// cycle. Each result leaves on o_result with o_valid high for one cycle;
// results keep input order. The depth is set by the square root of the
// Hertz law, which resolves one root bit per stage (24 stages), followed
// by the multiplier stages and the four-stage squared-magnitude compare
// of the no-tension rule. Every beat takes the same path, whatever the
// mode, so latency is constant.
// The force mode register is written over its own valid/ready channel;
// ready is always high. Write it only while no beat is in flight, since
// stages read it as the beat passes.
// Reset clears all valid bits and sets the mode to linear; beats in flight
// are dropped. The receiver cannot stall the block, so there is no
// backpressure path: a result is shown once and is gone the next cycle.
// ----------------------------------------------------------------------------
module contact_normal_force_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cnf_pkg::t_cnf_in  i_item,
    output logic              o_valid,
    output cnf_pkg::t_cnf_out o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);
    import cnf_pkg::*;

    // ---------------------------------------------------------------- config
    logic [2:0] r_mode;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- stage 0
    // Input register. The radicand is depth << 16, forced to zero when the
    // depth is not positive, where Hertz gives no spring force anyway.
    logic    r_v0;
    t_cnf_in r_in0;
    logic    accept;
    logic    d0_pos;
    logic [CNF_RAD_W-1:0] rad0;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in0 <= i_item;
        end
    end

    assign d0_pos = !r_in0.overlap_depth[31] && (r_in0.overlap_depth != 32'sd0);
    assign rad0   = d0_pos ? {1'b0, r_in0.overlap_depth[30:0], 16'h0000} : '0;

    // ---------------------------------------------------------- square root
    logic                  sq_v;
    logic [CNF_ROOT_W-1:0] sq_root;
    t_cnf_in               sq_item;

    cnf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_rad   (rad0),
        .i_item  (r_in0),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_item  (sq_item)
    );

    // ---------------------------------------------------------------- stage 1
    // First products: depth times root, linear spring, the three terms of
    // the direction-velocity dot product and the three damping products.
    logic                  r1_v;
    logic [38:0]           r1_p;
    logic signed [47:0]    r1_slin;
    logic signed [47:0]    r1_dot [3];
    logic signed [63:0]    r1_cv  [3];
    logic [31:0]           r1_kn;
    logic                  r1_dpos;
    logic signed [15:0]    r1_dir [3];

    logic [54:0]        hz_prod;
    logic signed [64:0] lin_prod;
    logic signed [15:0] s1_dir [3];
    logic signed [31:0] s1_vel [3];
    logic signed [64:0] cv_prod [3];
    logic signed [47:0] dot_prod [3];

    assign s1_dir[0] = sq_item.dir_x;
    assign s1_dir[1] = sq_item.dir_y;
    assign s1_dir[2] = sq_item.dir_z;
    assign s1_vel[0] = sq_item.vel_x;
    assign s1_vel[1] = sq_item.vel_y;
    assign s1_vel[2] = sq_item.vel_z;

    assign hz_prod  = {24'h000000, sq_item.overlap_depth[30:0]}
                    * {31'h00000000, sq_root};
    assign lin_prod = $signed({1'b0, sq_item.stiffness}) * sq_item.overlap_depth;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cv_prod[k]  = $signed({1'b0, sq_item.damping}) * s1_vel[k];
            dot_prod[k] = s1_dir[k] * s1_vel[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_v) begin
            r1_p    <= hz_prod[54:16];
            r1_slin <= lin_prod[63:16];
            r1_kn   <= sq_item.stiffness;
            r1_dpos <= !sq_item.overlap_depth[31] && (sq_item.overlap_depth != 32'sd0);
            for (int k = 0; k < 3; k++) begin
                r1_dot[k] <= dot_prod[k];
                r1_cv[k]  <= cv_prod[k][63:0];
                r1_dir[k] <= s1_dir[k];
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Hertz spring as two partial products; separation test; damping parts.
    logic                  r2_v;
    logic [54:0]           r2_a;
    logic [47:0]           r2_b;
    logic signed [47:0]    r2_slin;
    logic                  r2_sep;
    logic                  r2_dpos;
    logic signed [CNF_PART_W-1:0] r2_dp  [3];
    logic signed [15:0]    r2_dir [3];

    logic signed [49:0] dot_sum;
    logic signed [64:0] cv_neg [3];

    assign dot_sum = 50'(r1_dot[0]) + 50'(r1_dot[1]) + 50'(r1_dot[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cv_neg[k] = -65'(r1_cv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_v) begin
            r2_a    <= {23'h000000, r1_kn} * {32'h00000000, r1_p[38:16]};
            r2_b    <= {16'h0000, r1_kn} * {32'h00000000, r1_p[15:0]};
            r2_slin <= r1_slin;
            r2_sep  <= dot_sum[49];
            r2_dpos <= r1_dpos;
            for (int k = 0; k < 3; k++) begin
                r2_dp[k]  <= CNF_PART_W'($signed(cv_neg[k][64:16]));
                r2_dir[k] <= r1_dir[k];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Spring scalar by mode. Only the Hertz scalar can exceed 48 bits.
    logic                        r3_v;
    logic signed [CNF_FORCE_W-1:0] r3_s;
    logic                        r3_sat;
    logic                        r3_sep;
    logic signed [CNF_PART_W-1:0] r3_dp  [3];
    logic signed [15:0]          r3_dir [3];

    logic [55:0]                   hz_sum;
    logic                          hz_clip;
    logic signed [CNF_FORCE_W-1:0] s_sel;
    logic                          is_hertz;

    assign hz_sum   = {1'b0, r2_a} + {24'h000000, r2_b[47:16]};
    assign hz_clip  = |hz_sum[55:47];
    assign is_hertz = (r_mode == MODE_HERTZ);

    always_comb begin
        if (!is_hertz) begin
            s_sel = r2_slin;
        end else if (!r2_dpos) begin
            s_sel = '0;
        end else if (hz_clip) begin
            s_sel = CNF_FMAX;
        end else begin
            s_sel = hz_sum[CNF_FORCE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_v) begin
            r3_s   <= s_sel;
            r3_sat <= is_hertz && r2_dpos && hz_clip;
            r3_sep <= r2_sep;
            for (int k = 0; k < 3; k++) begin
                r3_dp[k]  <= r2_dp[k];
                r3_dir[k] <= r2_dir[k];
            end
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Spring scalar times direction.
    logic                         r4_v;
    logic signed [63:0]           r4_spp [3];
    logic                         r4_sat;
    logic                         r4_sep;
    logic signed [CNF_PART_W-1:0] r4_dp  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_v) begin
            r4_sat <= r3_sat;
            r4_sep <= r3_sep;
            for (int k = 0; k < 3; k++) begin
                r4_spp[k] <= r3_s * r3_dir[k];
                r4_dp[k]  <= r3_dp[k];
            end
        end
    end

    // ---------------------------------------------------------------- stage 5
    // Spring parts, negated and shifted down by the Q2.14 direction scale,
    // plus the mode decisions for this beat.
    logic                         r5_v;
    logic signed [CNF_PART_W-1:0] r5_sp [3];
    logic signed [CNF_PART_W-1:0] r5_dp [3];
    logic                         r5_sat;
    logic                         r5_use_sp;
    logic                         r5_zero_en;

    logic signed [63:0] spp_neg [3];
    logic               mode_bonded;
    logic               mode_nt;

    assign mode_bonded = (r_mode == MODE_BONDED) || (r_mode == MODE_BONDED_NT);
    assign mode_nt     = (r_mode == MODE_NO_TENSION) || (r_mode == MODE_BONDED_NT);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            spp_neg[k] = -r4_spp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_v) begin
            r5_sat     <= r4_sat;
            r5_use_sp  <= !(mode_bonded && !r4_sep);
            r5_zero_en <= mode_nt && r4_sep;
            for (int k = 0; k < 3; k++) begin
                r5_sp[k] <= spp_neg[k][63:14];
                r5_dp[k] <= r4_dp[k];
            end
        end
    end

    // -------------------------------------------------- squared magnitudes
    logic                 sm_sp_v;
    logic                 sm_dp_v;
    logic [CNF_SUM_W-1:0] sm_sp;
    logic [CNF_SUM_W-1:0] sm_dp;

    cnf_sqmag u_sqmag_sp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_val   (r5_sp),
        .o_valid (sm_sp_v),
        .o_sum   (sm_sp)
    );

    cnf_sqmag u_sqmag_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_val   (r5_dp),
        .o_valid (sm_dp_v),
        .o_sum   (sm_dp)
    );

    // ------------------------------------------------------- force path
    // The clipped force is formed in the first of these stages and then
    // waits beside the squared-magnitude units.
    t_cnf_tail                    r_tail [CNF_SQ_STAGES];
    t_cnf_tail                    n_tail;
    logic signed [CNF_PART_W:0]   fsum   [3];
    logic signed [CNF_FORCE_W-1:0] fclip [3];
    logic [2:0]                   fhit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fsum[k] = (CNF_PART_W+1)'(r5_dp[k])
                    + (r5_use_sp ? (CNF_PART_W+1)'(r5_sp[k]) : '0);
            if (fsum[k] > (CNF_PART_W+1)'(CNF_FMAX)) begin
                fclip[k] = CNF_FMAX;
                fhit[k]  = 1'b1;
            end else if (fsum[k] < (CNF_PART_W+1)'(CNF_FMIN)) begin
                fclip[k] = CNF_FMIN;
                fhit[k]  = 1'b1;
            end else begin
                fclip[k] = fsum[k][CNF_FORCE_W-1:0];
                fhit[k]  = 1'b0;
            end
        end
        n_tail.f_x     = fclip[0];
        n_tail.f_y     = fclip[1];
        n_tail.f_z     = fclip[2];
        n_tail.f_sat   = |fhit;
        n_tail.s_sat   = r5_sat;
        n_tail.zero_en = r5_zero_en;
    end

    always_ff @(posedge i_clk) begin
        if (r5_v) begin
            r_tail[0] <= n_tail;
        end
        for (int k = 1; k < CNF_SQ_STAGES; k++) begin
            r_tail[k] <= r_tail[k-1];
        end
    end

    // ---------------------------------------------------------- output stage
    // No-tension rule: zero the force when the damping magnitude wins.
    logic      r_ov;
    t_cnf_out  r_out;
    t_cnf_out  n_out;
    logic      zeroed;
    t_cnf_tail tl;

    assign tl     = r_tail[CNF_SQ_STAGES-1];
    assign zeroed = tl.zero_en && (sm_dp > sm_sp);

    always_comb begin
        n_out.force_x      = zeroed ? '0 : tl.f_x;
        n_out.force_y      = zeroed ? '0 : tl.f_y;
        n_out.force_z      = zeroed ? '0 : tl.f_z;
        n_out.force_zeroed = zeroed;
        n_out.saturated    = tl.s_sat || (!zeroed && tl.f_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= sm_sp_v && sm_dp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sm_sp_v && sm_dp_v) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/cnf_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root, one root bit per register stage, with the
// contact beat carried alongside.
// ----------------------------------------------------------------------------
module cnf_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [cnf_pkg::CNF_RAD_W-1:0]  i_rad,
    input  cnf_pkg::t_cnf_in               i_item,
    output logic                           o_valid,
    output logic [cnf_pkg::CNF_ROOT_W-1:0] o_root,
    output cnf_pkg::t_cnf_in               o_item
);
    import cnf_pkg::*;

    localparam int REM_W = CNF_ROOT_W + 3;

    logic                  w_v    [CNF_SQRT_STAGES+1];
    logic [CNF_ROOT_W-1:0] w_q    [CNF_SQRT_STAGES+1];
    logic [REM_W-1:0]      w_rem  [CNF_SQRT_STAGES+1];
    logic [CNF_RAD_W-1:0]  w_x    [CNF_SQRT_STAGES+1];
    t_cnf_in               w_item [CNF_SQRT_STAGES+1];

    assign w_v[0]    = i_valid;
    assign w_q[0]    = '0;
    assign w_rem[0]  = '0;
    assign w_x[0]    = i_rad;
    assign w_item[0] = i_item;

    for (genvar g = 0; g < CNF_SQRT_STAGES; g++) begin : g_stage
        logic                  r_v;
        logic [CNF_ROOT_W-1:0] r_q;
        logic [REM_W-1:0]      r_rem;
        logic [CNF_RAD_W-1:0]  r_x;
        t_cnf_in               r_item;
        logic [REM_W-1:0]      rs;
        logic [REM_W-1:0]      trial;
        logic                  take;

        // Bring down the next two radicand bits and try root bit one.
        assign rs    = {w_rem[g][REM_W-3:0], w_x[g][CNF_RAD_W-1 -: 2]};
        assign trial = {1'b0, w_q[g], 2'b01};
        assign take  = (rs >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_v[g]) begin
                r_q    <= {w_q[g][CNF_ROOT_W-2:0], take};
                r_rem  <= take ? (rs - trial) : rs;
                r_x    <= {w_x[g][CNF_RAD_W-3:0], 2'b00};
                r_item <= w_item[g];
            end
        end

        assign w_v[g+1]    = r_v;
        assign w_q[g+1]    = r_q;
        assign w_rem[g+1]  = r_rem;
        assign w_x[g+1]    = r_x;
        assign w_item[g+1] = r_item;
    end

    assign o_valid = w_v[CNF_SQRT_STAGES];
    assign o_root  = w_q[CNF_SQRT_STAGES];
    assign o_item  = w_item[CNF_SQRT_STAGES];

    // The final remainder is not needed; keep it observed for lint.
    logic unused_rem;
    assign unused_rem = ^w_rem[CNF_SQRT_STAGES] ^ ^w_x[CNF_SQRT_STAGES];

endmodule

// ===== hw/rtl/cnf_sqmag.sv =====
// ----------------------------------------------------------------------------
// Squared magnitude of a three-component vector
// Absolute value, split partial products, square assembly and sum, one
// register stage each.
// ----------------------------------------------------------------------------
module cnf_sqmag (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [cnf_pkg::CNF_PART_W-1:0] i_val [3],
    output logic                                 o_valid,
    output logic [cnf_pkg::CNF_SUM_W-1:0]        o_sum
);
    import cnf_pkg::*;

    localparam int HALF_W = CNF_PART_W / 2;

    logic [CNF_SQ_STAGES-1:0] r_v;
    logic [CNF_PART_W-1:0]    r_abs [3];
    logic [2*HALF_W-1:0]      r_hh  [3];
    logic [2*HALF_W-1:0]      r_hl  [3];
    logic [2*HALF_W-1:0]      r_ll  [3];
    logic [CNF_SQ_W-1:0]      r_sq  [3];
    logic [CNF_SUM_W-1:0]     r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CNF_SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_valid) begin
                r_abs[k] <= i_val[k][CNF_PART_W-1] ? CNF_PART_W'(-i_val[k])
                                                   : CNF_PART_W'(i_val[k]);
            end
            if (r_v[0]) begin
                r_hh[k] <= r_abs[k][CNF_PART_W-1:HALF_W] * r_abs[k][CNF_PART_W-1:HALF_W];
                r_hl[k] <= r_abs[k][CNF_PART_W-1:HALF_W] * r_abs[k][HALF_W-1:0];
                r_ll[k] <= r_abs[k][HALF_W-1:0] * r_abs[k][HALF_W-1:0];
            end
            if (r_v[1]) begin
                r_sq[k] <= {r_hh[k], {(2*HALF_W){1'b0}}}
                         + {{(HALF_W-1){1'b0}}, r_hl[k], {(HALF_W+1){1'b0}}}
                         + {{(2*HALF_W){1'b0}}, r_ll[k]};
            end
        end
        if (r_v[2]) begin
            r_sum <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        end
    end

    assign o_valid = r_v[CNF_SQ_STAGES-1];
    assign o_sum   = r_sum;

endmodule

// ===== hw/rtl/cnf_checker.sv =====
// ----------------------------------------------------------------------------
// Contact normal force port checker
// Watches the top-level ports for latency, spurious-result and zeroing rules.
// ----------------------------------------------------------------------------
`include "contact_normal_force_top_macros.svh"

module cnf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input cnf_pkg::t_cnf_in  i_item,
    input logic              o_valid,
    input cnf_pkg::t_cnf_out o_result,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [2:0]        i_cfg_data
);
    import cnf_pkg::*;

    logic acc;
    logic zero_ok;
    logic unused_ports;

    assign acc          = start && !busy;
    assign zero_ok      = (o_result.force_x == '0) && (o_result.force_y == '0)
                          && (o_result.force_z == '0);
    assign unused_ports = ^i_item ^ i_cfg_valid ^ o_cfg_ready ^ ^i_cfg_data;

    // Every accepted beat yields a result after the fixed pipeline depth.
    `CNF_ASSERT_DLY(a_latency, i_clk, i_rst_n, acc, CNF_LATENCY, o_valid)

    // No result appears unless a beat was accepted the full pipeline depth before it.
    `CNF_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_valid, $past(acc, CNF_LATENCY))

    // A zeroed result carries an all-zero force.
    `CNF_ASSERT_IMP(a_zeroed_force, i_clk, i_rst_n, o_valid && o_result.force_zeroed, zero_ok)

endmodule

bind contact_normal_force_top cnf_checker u_cnf_checker (.*);
